FILE: sv/pcpf_pkg.sv
// Shared types and constants of the pixel color point filter.
// No dependencies; every other file imports this package.
package pcpf_pkg;

  localparam int CH_W       = 8;
  localparam int LVL_W      = 9;
  localparam int MODE_W     = 4;
  localparam int IDX_W      = 2;
  localparam int DIV_STAGES = 8;
  localparam int HUE_FULL   = 65280;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_LEVEL = 2'd1;

  // effect codes
  localparam logic [MODE_W-1:0] MODE_PASS     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_NEGATIVE = 4'd1;
  localparam logic [MODE_W-1:0] MODE_AVG_GREY = 4'd2;
  localparam logic [MODE_W-1:0] MODE_LUMA     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BRIGHT   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CONTRAST = 4'd5;
  localparam logic [MODE_W-1:0] MODE_THRESH   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_POSTER   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_HUE      = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SPLASH   = 4'd9;

  // one stage of the divider pipeline: hue division and three posterize divisions
  typedef struct packed {
    logic             vld;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [7:0]       mx;
    logic [7:0]       mn;
    logic [7:0]       dl;
    logic [7:0]       y;
    logic [23:0]      basic;
    logic [26:0]      hrem;
    logic [26:0]      hdsh;
    logic [15:0]      hq;
    logic [2:0][15:0] prem;
    logic [30:0]      pdsh;
    logic [2:0][15:0] pq;
  } div_t;

endpackage

FILE: sv/pcpf_in_if.sv
// Input pixel channel: valid/ready handshake and one RGB word.
// Depends on pcpf_pkg.
interface pcpf_in_if;
  import pcpf_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

FILE: sv/pcpf_out_if.sv
// Output pixel channel: valid/ready handshake and one filtered RGB word.
// Depends on pcpf_pkg.
interface pcpf_out_if;
  import pcpf_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  modport source (output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

FILE: sv/pcpf_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pcpf_pkg.
interface pcpf_cfg_if;
  import pcpf_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [LVL_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/pixel_color_point_filter.sv
// Pixel color point filter top level: config registers and the pixel pipeline.
// Depends on pcpf_pkg, pcpf_in_if, pcpf_out_if, pcpf_cfg_if, pcpf_div_stage.
//
//   port      dir  word                          handshake
//   in_pix    in   red_in, green_in, blue_in     valid/ready
//   out_pix   out  red_out, green_out, blue_out  valid/ready
//   cfg_wr    in   index, data                   valid/ready (ready always high)
//
// One pixel per clock while out_pix is not stalled; 13 register stages (capture,
// prepare, 8 divider stages of 2 quotient bits, 2 hue stages, output). The 16-bit
// hue quotient sets the depth. Reset clears the config registers and all valid
// bits. A stall on out_pix freezes every stage at once; nothing is dropped.
module pixel_color_point_filter (
  input  logic      clk,
  input  logic      rst_n,
  pcpf_in_if.sink   in_pix,
  pcpf_out_if.source out_pix,
  pcpf_cfg_if.sink  cfg_wr
);
  import pcpf_pkg::*;

  typedef struct packed {
    logic            vld;
    logic [7:0]      r;
    logic [7:0]      g;
    logic [7:0]      b;
    logic [7:0]      mx;
    logic [7:0]      mn;
    logic [7:0]      dl;
    logic [7:0]      y;
    logic [23:0]     basic;
    logic [2:0][7:0] post;
    logic            keep;
    logic [2:0]      k;
    logic [15:0]     f;
  } post_a_t;

  typedef struct packed {
    logic            vld;
    logic [7:0]      r;
    logic [7:0]      g;
    logic [7:0]      b;
    logic [7:0]      mx;
    logic [7:0]      mn;
    logic [7:0]      dl;
    logic [7:0]      y;
    logic [23:0]     basic;
    logic [2:0][7:0] post;
    logic            keep;
    logic [2:0]      k;
    logic [23:0]     p1;
    logic [23:0]     p2;
  } post_b_t;

  logic [MODE_W-1:0] mode_r;
  logic [LVL_W-1:0]  level_r;
  logic [LVL_W-1:0]  lvl;
  logic              en;
  logic [15:0]       pd;
  logic [15:0]       hue_c;

  // configuration
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PASS;
      level_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_MODE:  mode_r  <= cfg_wr.data[MODE_W-1:0];
        REG_LEVEL: level_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign lvl   = (level_r > 9'd256) ? 9'd256 : level_r;
  assign pd    = 16'd2048 + 16'(lvl) * 16'd120;
  assign hue_c = 16'({lvl, 8'd0} - {8'd0, lvl});

  // global advance: the whole pipe moves unless the output word is held
  logic out_valid_r;
  assign en           = !out_valid_r || out_pix.ready;
  assign in_pix.ready = en;

  // stage 0: capture
  logic       s0_vld_r;
  logic [7:0] s0_r_r, s0_g_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_pix.valid;
      s0_r_r   <= in_pix.red_in;
      s0_g_r   <= in_pix.green_in;
      s0_b_r   <= in_pix.blue_in;
    end
  end

  // stage 1: extrema, hue numerator, luma, divider operands, simple effects
  function automatic logic [7:0] bright(input logic [7:0] x, input logic [8:0] l);
    logic signed [10:0] t;
    t = $signed({3'b0, x}) + $signed({2'b0, l}) - 11'sd128;
    if (t < 0) return 8'd0;
    if (t > 11'sd255) return 8'd255;
    return t[7:0];
  endfunction

  function automatic logic [7:0] contrast(input logic [7:0] x, input logic [8:0] l);
    logic signed [9:0]  xs;
    logic signed [10:0] l3;
    logic signed [21:0] v;
    xs = $signed({2'b0, x}) - 10'sd128;
    l3 = $signed({2'b0, l} + {1'b0, l, 1'b0});
    v  = xs * l3;
    v  = v + 22'sd32768;
    if (v < 0) return 8'd0;
    if (v[21:16] != 6'd0) return 8'd255;
    return v[15:8];
  endfunction

  div_t              s1_nxt;
  div_t              s1_r;
  logic [7:0]        mx, mn, dl;
  logic [10:0]       dd;
  logic signed [11:0] hs;
  logic [23:0]       luma;
  logic [9:0]        sum3;
  logic [19:0]       avg_p;
  logic [7:0]        avg;
  logic              dark;
  logic [2:0][7:0]   pix;

  always_comb begin
    pix  = {s0_b_r, s0_g_r, s0_r_r};
    mx   = (s0_r_r >= s0_g_r) ? s0_r_r : s0_g_r;
    if (s0_b_r > mx) mx = s0_b_r;
    mn   = (s0_r_r <= s0_g_r) ? s0_r_r : s0_g_r;
    if (s0_b_r < mn) mn = s0_b_r;
    dl   = mx - mn;
    dd   = {2'b0, dl, 1'b0} + {1'b0, dl, 2'b0};
    if (s0_r_r == mx) begin
      hs = $signed({4'd0, s0_g_r}) - $signed({4'd0, s0_b_r});
      if (hs < 0) hs = hs + $signed({1'b0, dd});
    end else if (s0_g_r == mx) begin
      hs = $signed({3'd0, dl, 1'b0}) + $signed({4'd0, s0_b_r}) - $signed({4'd0, s0_r_r});
    end else begin
      hs = $signed({2'd0, dl, 2'b0}) + $signed({4'd0, s0_r_r}) - $signed({4'd0, s0_g_r});
    end

    luma  = 24'(s0_r_r) * 24'd19595 + 24'(s0_g_r) * 24'd38470 + 24'(s0_b_r) * 24'd7471;
    sum3  = 10'(s0_r_r) + 10'(s0_g_r) + 10'(s0_b_r);
    avg_p = 20'(sum3) * 20'd683;
    avg   = avg_p[18:11];
    dark  = {1'b0, luma} < ({lvl, 16'd0} - {8'd0, lvl, 8'd0});

    s1_nxt.vld  = s0_vld_r;
    s1_nxt.r    = s0_r_r;
    s1_nxt.g    = s0_g_r;
    s1_nxt.b    = s0_b_r;
    s1_nxt.mx   = mx;
    s1_nxt.mn   = mn;
    s1_nxt.dl   = dl;
    s1_nxt.y    = luma[23:16];
    s1_nxt.hrem = {hs[10:0], 16'd0} - {8'd0, hs[10:0], 8'd0};
    s1_nxt.hdsh = {1'b0, dd, 15'd0};
    s1_nxt.hq   = '0;
    s1_nxt.pdsh = {pd, 15'd0};
    for (int i = 0; i < 3; i++) begin
      s1_nxt.prem[i] = {pix[i], 8'd0};
      s1_nxt.pq[i]   = '0;
    end

    case (mode_r)
      MODE_NEGATIVE: s1_nxt.basic = ~{s0_b_r, s0_g_r, s0_r_r};
      MODE_AVG_GREY: s1_nxt.basic = {avg, avg, avg};
      MODE_LUMA:     s1_nxt.basic = {3{luma[23:16]}};
      MODE_BRIGHT:   s1_nxt.basic = {bright(s0_b_r, lvl), bright(s0_g_r, lvl),
                                     bright(s0_r_r, lvl)};
      MODE_CONTRAST: s1_nxt.basic = {contrast(s0_b_r, lvl), contrast(s0_g_r, lvl),
                                     contrast(s0_r_r, lvl)};
      MODE_THRESH:   s1_nxt.basic = dark ? 24'd0 : 24'hFFFFFF;
      default:       s1_nxt.basic = {s0_b_r, s0_g_r, s0_r_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // divider stages
  div_t dchain [DIV_STAGES+1];
  assign dchain[0] = s1_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    pcpf_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (dchain[k]),
      .d_o   (dchain[k+1])
    );
  end

  // stage A: rotate hue, sector split, splash distance, posterize rebuild
  div_t        dv;
  post_a_t     a_nxt, a_r;
  logic [15:0] hq;
  logic [16:0] hr;
  logic [18:0] s6;
  logic [15:0] hue_dist;
  logic [20:0] pp;

  assign dv = dchain[DIV_STAGES];

  always_comb begin
    hq = (dv.dl == 8'd0) ? 16'd0 : dv.hq;
    hr = {1'b0, hq} + {1'b0, hue_c};
    if (hr >= 17'(HUE_FULL)) hr = hr - 17'(HUE_FULL);
    s6 = {1'b0, hr[15:0], 2'b0} + {2'b0, hr[15:0], 1'b0};

    a_nxt.vld   = dv.vld;
    a_nxt.r     = dv.r;
    a_nxt.g     = dv.g;
    a_nxt.b     = dv.b;
    a_nxt.mx    = dv.mx;
    a_nxt.mn    = dv.mn;
    a_nxt.dl    = dv.dl;
    a_nxt.y     = dv.y;
    a_nxt.basic = dv.basic;

    if (s6 >= 19'(5 * HUE_FULL)) begin
      a_nxt.k = 3'd5; a_nxt.f = 16'(s6 - 19'(5 * HUE_FULL));
    end else if (s6 >= 19'(4 * HUE_FULL)) begin
      a_nxt.k = 3'd4; a_nxt.f = 16'(s6 - 19'(4 * HUE_FULL));
    end else if (s6 >= 19'(3 * HUE_FULL)) begin
      a_nxt.k = 3'd3; a_nxt.f = 16'(s6 - 19'(3 * HUE_FULL));
    end else if (s6 >= 19'(2 * HUE_FULL)) begin
      a_nxt.k = 3'd2; a_nxt.f = 16'(s6 - 19'(2 * HUE_FULL));
    end else if (s6 >= 19'(HUE_FULL)) begin
      a_nxt.k = 3'd1; a_nxt.f = 16'(s6 - 19'(HUE_FULL));
    end else begin
      a_nxt.k = 3'd0; a_nxt.f = s6[15:0];
    end

    hue_dist = (hq > hue_c) ? hq - hue_c : hue_c - hq;
    if (hue_dist > 16'd32512) hue_dist = 16'(HUE_FULL) - hue_dist;
    a_nxt.keep = hue_dist < 16'd5120;

    pp = '0;
    for (int i = 0; i < 3; i++) begin
      pp = 21'(dv.pq[i][4:0]) * 21'(pd);
      a_nxt.post[i] = pp[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
    end
  end

  // stage B: interpolation products
  post_b_t b_nxt, b_r;

  always_comb begin
    b_nxt.vld   = a_r.vld;
    b_nxt.r     = a_r.r;
    b_nxt.g     = a_r.g;
    b_nxt.b     = a_r.b;
    b_nxt.mx    = a_r.mx;
    b_nxt.mn    = a_r.mn;
    b_nxt.dl    = a_r.dl;
    b_nxt.y     = a_r.y;
    b_nxt.basic = a_r.basic;
    b_nxt.post  = a_r.post;
    b_nxt.keep  = a_r.keep;
    b_nxt.k     = a_r.k;
    b_nxt.p1    = 24'(a_r.dl) * 24'(a_r.f);
    b_nxt.p2    = 24'(a_r.dl) * 24'(16'(HUE_FULL) - a_r.f);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
    end else if (en) begin
      b_r <= b_nxt;
    end
  end

  // output stage: ceil division by 65280 as ceil by 256, then ceil by 255
  function automatic logic [7:0] ceil_div(input logic [23:0] p);
    logic [23:0] c;
    logic [31:0] m;
    c = (p + 24'd255) >> 8;
    m = 32'(c[15:0] + 16'd254) * 32'd32897;
    return m[30:23];
  endfunction

  logic [7:0]  qv, tv;
  logic [23:0] o_nxt;
  logic [23:0] o_r;

  always_comb begin
    qv = b_r.mx - ceil_div(b_r.p1);
    tv = b_r.mx - ceil_div(b_r.p2);
    case (mode_r)
      MODE_POSTER: o_nxt = b_r.post;
      MODE_HUE: begin
        if (b_r.dl == 8'd0) begin
          o_nxt = {b_r.b, b_r.g, b_r.r};
        end else begin
          case (b_r.k)
            3'd0:    o_nxt = {b_r.mn, tv, b_r.mx};
            3'd1:    o_nxt = {b_r.mn, b_r.mx, qv};
            3'd2:    o_nxt = {tv, b_r.mx, b_r.mn};
            3'd3:    o_nxt = {b_r.mx, qv, b_r.mn};
            3'd4:    o_nxt = {b_r.mx, b_r.mn, tv};
            default: o_nxt = {qv, b_r.mn, b_r.mx};
          endcase
        end
      end
      MODE_SPLASH: o_nxt = b_r.keep ? {b_r.b, b_r.g, b_r.r} : {3{b_r.y}};
      default:     o_nxt = b_r.basic;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b_r.vld;
      o_r         <= o_nxt;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.red_out   = o_r[7:0];
  assign out_pix.green_out = o_r[15:8];
  assign out_pix.blue_out  = o_r[23:16];
endmodule

FILE: sv/pcpf_div_stage.sv
// One registered stage of the restoring dividers: two quotient bits per word.
// Depends on pcpf_pkg (div_t).
module pcpf_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  pcpf_pkg::div_t d_i,
  output pcpf_pkg::div_t d_o
);
  import pcpf_pkg::*;

  div_t d_r;
  div_t d_mid;
  div_t d_nxt;

  function automatic div_t div_step(input div_t d);
    div_t o;
    logic hb;
    o  = d;
    hb = (d.hrem >= d.hdsh);
    if (hb) o.hrem = d.hrem - d.hdsh;
    o.hq   = {d.hq[14:0], hb};
    o.hdsh = d.hdsh >> 1;
    for (int i = 0; i < 3; i++) begin
      if ({15'd0, d.prem[i]} >= d.pdsh) begin
        o.prem[i] = d.prem[i] - d.pdsh[15:0];
        o.pq[i]   = {d.pq[i][14:0], 1'b1};
      end else begin
        o.pq[i]   = {d.pq[i][14:0], 1'b0};
      end
    end
    o.pdsh = d.pdsh >> 1;
    return o;
  endfunction

  always_comb begin
    d_mid = div_step(d_i);
    d_nxt = div_step(d_mid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule
